[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks included by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

[rtl/hrf_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP request framer package
// Phase codes, character constants, match strings and small lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package hrf_pkg;

   localparam int unsigned LENGTH_BITS_DEF = 32;
   localparam logic [31:0] BODY_LIMIT_RESET = 32'd1048576;
   localparam int unsigned STR_W = 256;

   typedef enum logic [8:0] {
      PH_REQ   = 9'b000000001,
      PH_HKEY  = 9'b000000010,
      PH_HVAL  = 9'b000000100,
      PH_CSIZE = 9'b000001000,
      PH_CDATA = 9'b000010000,
      PH_CEND  = 9'b000100000,
      PH_BODY  = 9'b001000000,
      PH_DONE  = 9'b010000000,
      PH_FAIL  = 9'b100000000
   } phase_type;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_PATH = 2'd1;
   localparam logic [1:0] KIND_BODY = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD      = 2'd1;
   localparam logic [1:0] ERR_TOOLARGE = 2'd2;
   localparam logic [1:0] ERR_REQLINE  = 2'd3;

   localparam logic [1:0] METH_NONE   = 2'd0;
   localparam logic [1:0] METH_GET    = 2'd1;
   localparam logic [1:0] METH_POST   = 2'd2;
   localparam logic [1:0] METH_DELETE = 2'd3;

   localparam logic [2:0] KEY_HOST  = 3'd0;
   localparam logic [2:0] KEY_CLEN  = 3'd1;
   localparam logic [2:0] KEY_TENC  = 3'd2;
   localparam logic [2:0] KEY_CONN  = 3'd3;
   localparam logic [2:0] KEY_NONE  = 3'd4;

   // header flag bit positions
   localparam int unsigned HF_HOST    = 0;
   localparam int unsigned HF_CL      = 1;
   localparam int unsigned HF_CHUNKED = 2;
   localparam int unsigned HF_CLOSE   = 3;
   localparam int unsigned HF_CLBAD   = 4;
   localparam int unsigned HF_CLOVER  = 5;

   // value match bit positions
   localparam int unsigned VM_ALIVE = 0;
   localparam int unsigned VM_START = 1;
   localparam int unsigned VM_TRAIL = 2;
   localparam int unsigned VM_BAD   = 3;
   localparam int unsigned VM_OVER  = 4;

   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [STR_W-1:0] STR_GET     = STR_W'("GET");
   localparam logic [STR_W-1:0] STR_POST    = STR_W'("POST");
   localparam logic [STR_W-1:0] STR_DELETE  = STR_W'("DELETE");
   localparam logic [STR_W-1:0] STR_VERSION = STR_W'("HTTP/1.1");
   localparam logic [STR_W-1:0] STR_HOST    = STR_W'("host");
   localparam logic [STR_W-1:0] STR_CLEN    = STR_W'("content-length");
   localparam logic [STR_W-1:0] STR_TENC    = STR_W'("transfer-encoding");
   localparam logic [STR_W-1:0] STR_CONN    = STR_W'("connection");
   localparam logic [STR_W-1:0] STR_CHUNKED = STR_W'("chunked");
   localparam logic [STR_W-1:0] STR_CLOSE   = STR_W'("close");

   localparam logic [4:0] LEN_VERSION = 5'd8;
   localparam logic [4:0] LEN_CHUNKED = 5'd7;
   localparam logic [4:0] LEN_CLOSE   = 5'd5;

   // character at position p of a right-aligned string of length len
   function automatic logic [7:0] str_chr(input logic [STR_W-1:0] s, input logic [4:0] len,
                                          input logic [4:0] p);
      logic [4:0] idx;
      idx = len - p - 5'd1;
      return s[{idx, 3'b000} +: 8];
   endfunction

   function automatic logic [STR_W-1:0] meth_str(input logic [1:0] i);
      case (i)
         2'd0:    return STR_GET;
         2'd1:    return STR_POST;
         default: return STR_DELETE;
      endcase
   endfunction

   function automatic logic [4:0] meth_len(input logic [1:0] i);
      case (i)
         2'd0:    return 5'd3;
         2'd1:    return 5'd4;
         default: return 5'd6;
      endcase
   endfunction

   function automatic logic [STR_W-1:0] key_str(input logic [1:0] i);
      case (i)
         2'd0:    return STR_HOST;
         2'd1:    return STR_CLEN;
         2'd2:    return STR_TENC;
         default: return STR_CONN;
      endcase
   endfunction

   function automatic logic [4:0] key_len(input logic [1:0] i);
      case (i)
         2'd0:    return 5'd4;
         2'd1:    return 5'd14;
         2'd2:    return 5'd17;
         default: return 5'd10;
      endcase
   endfunction

   // {valid, value} of a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

`default_nettype wire

[rtl/http_request_framer.sv]
// Each result is registered and appears in the cycle after its byte is transferred in.
// Throughput: one byte per cycle unless rsp_ready stalls; the per-byte matcher
// and the x10 / x16 number accumulators lie between state and result registers.
// Reset: synchronous, active high; returns to the request line phase with
// body_limit at 1048576 and no result pending.
// ----------------------------------------------------------------------------
// HTTP request framer
// Parses an HTTP/1.1 request byte by byte, streams path and body bytes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module http_request_framer
   import hrf_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_byte_kind,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_finished,
   output logic             rsp_failed,
   output logic [1:0]       rsp_error_kind,
   output logic [1:0]       rsp_method_code,
   output logic             rsp_keep_alive,
   output logic [31:0]      rsp_body_count,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   localparam int unsigned LB    = LENGTH_BITS;
   localparam int unsigned CMP_W = (LB > 32) ? LB : 32;

   typedef struct packed {
      phase_type       phase;
      logic [1:0]      token_index;
      logic [4:0]      wmask;
      logic [4:0]      mpos;
      logic [5:0]      hflags;
      logic [LB-1:0]   number;
      logic [LB-1:0]   content_length;
      logic [LB-1:0]   chunk_remaining;
      logic [1:0]      err;
      logic [1:0]      method;
      logic            in_token;
      logic [2:0]      key_sel;
      logic [1:0]      kind;
      logic [7:0]      data;
   } st_type;

   st_type       st_ff, st_in;
   logic         pcr_ff, pcr_in;
   logic [31:0]  bc_ff, bc_in;
   logic [31:0]  limit_ff;
   logic         done;
   logic         accept;

   logic         rsp_valid_ff;
   logic [1:0]   kind_ff;
   logic [7:0]   data_ff;
   logic         finished_ff, failed_ff, keep_ff;
   logic [1:0]   err_ff, meth_ff;
   logic [31:0]  count_ff;

   function automatic st_type fail_with(input st_type s, input logic [1:0] code);
      s.phase = PH_FAIL;
      s.err   = code;
      return s;
   endfunction

   function automatic st_type bump(input st_type s);
      if (s.mpos != 5'd31) s.mpos = s.mpos + 5'd1;
      return s;
   endfunction

   function automatic st_type start_key(input st_type s);
      s.phase = PH_HKEY;
      s.mpos  = 5'd0;
      s.wmask = 5'd15;
      return s;
   endfunction

   function automatic st_type end_token(input st_type s);
      logic bad;
      bad = 1'b0;
      s.in_token = 1'b0;
      if (s.token_index == 2'd0) begin
         if (s.wmask[0] && s.mpos == meth_len(2'd0)) s.method = METH_GET;
         else if (s.wmask[1] && s.mpos == meth_len(2'd1)) s.method = METH_POST;
         else if (s.wmask[2] && s.mpos == meth_len(2'd2)) s.method = METH_DELETE;
         if (s.method == METH_NONE) bad = 1'b1;
      end else if (s.token_index == 2'd2) begin
         if (!(s.wmask[0] && s.mpos == LEN_VERSION)) bad = 1'b1;
      end
      if (bad) begin
         s = fail_with(s, ERR_REQLINE);
      end else if (s.token_index != 2'd3) begin
         s.token_index = s.token_index + 2'd1;
      end
      return s;
   endfunction

   function automatic st_type rl_byte(input st_type s, input logic [7:0] c);
      if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR) begin
         if (s.in_token) s = end_token(s);
      end else begin
         if (!s.in_token) begin
            s.in_token = 1'b1;
            s.mpos     = 5'd0;
            s.wmask    = (s.token_index == 2'd0) ? 5'd7 : ((s.token_index == 2'd2) ? 5'd1 : 5'd0);
         end
         if (s.token_index == 2'd0) begin
            for (int i = 0; i < 3; i++) begin
               if (s.wmask[i] && (s.mpos >= meth_len(2'(i)) ||
                   str_chr(meth_str(2'(i)), meth_len(2'(i)), s.mpos) != c))
                  s.wmask[i] = 1'b0;
            end
         end else if (s.token_index == 2'd2) begin
            if (s.wmask[0] && (s.mpos >= LEN_VERSION ||
                str_chr(STR_VERSION, LEN_VERSION, s.mpos) != c))
               s.wmask = 5'd0;
         end else if (s.token_index == 2'd1) begin
            s.kind = KIND_PATH;
            s.data = c;
         end
         s = bump(s);
      end
      return s;
   endfunction

   function automatic st_type key_byte(input st_type s, input logic [7:0] c);
      logic [7:0] lc;
      lc = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
      if (c == CH_COLON) begin
         s.key_sel = KEY_NONE;
         for (int i = 0; i < 4; i++) begin
            if (s.wmask[i] && s.mpos == key_len(2'(i))) s.key_sel = 3'(i);
         end
         s.phase  = PH_HVAL;
         s.wmask  = 5'd1;
         s.mpos   = 5'd0;
         s.number = '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            if (s.wmask[i] && (s.mpos >= key_len(2'(i)) ||
                str_chr(key_str(2'(i)), key_len(2'(i)), s.mpos) != lc))
               s.wmask[i] = 1'b0;
         end
         s = bump(s);
      end
      return s;
   endfunction

   function automatic st_type val_byte(input st_type s, input logic [7:0] c);
      logic [LB+3:0]    prod;
      logic [STR_W-1:0] t;
      logic [4:0]       tl;
      logic [7:0]       d;
      d = c - 8'h30;
      prod = ({4'd0, s.number} << 3) + ({4'd0, s.number} << 1) + (LB+4)'(d[3:0]);
      t  = (s.key_sel == KEY_TENC) ? STR_CHUNKED : STR_CLOSE;
      tl = (s.key_sel == KEY_TENC) ? LEN_CHUNKED : LEN_CLOSE;
      if (s.key_sel != KEY_HOST && s.key_sel < KEY_NONE) begin
         if (c == CH_SP || c == CH_TAB) begin
            if (s.wmask[VM_START]) s.wmask[VM_TRAIL] = 1'b1;
         end else begin
            if (s.wmask[VM_TRAIL]) begin
               s.wmask[VM_BAD]   = 1'b1;
               s.wmask[VM_ALIVE] = 1'b0;
            end
            s.wmask[VM_START] = 1'b1;
            if (s.key_sel == KEY_CLEN) begin
               if (c inside {[8'h30:8'h39]}) begin
                  if (prod[LB+3:LB] != 4'd0) s.wmask[VM_OVER] = 1'b1;
                  else s.number = prod[LB-1:0];
               end else begin
                  s.wmask[VM_BAD] = 1'b1;
               end
            end else begin
               if (s.wmask[VM_ALIVE] && (s.mpos >= tl || str_chr(t, tl, s.mpos) != c))
                  s.wmask[VM_ALIVE] = 1'b0;
               s = bump(s);
            end
         end
      end
      return s;
   endfunction

   function automatic st_type csize_byte(input st_type s, input logic [7:0] c);
      logic [4:0] h;
      logic       skip;
      h = hex_val(c);
      skip = 1'b0;
      if (s.mpos == 5'd0) begin
         if (c == CH_SP || c == CH_TAB) skip = 1'b1;
         else s.mpos = h[4] ? 5'd1 : 5'd3;
      end else if (s.mpos == 5'd1) begin
         if (!h[4]) s.mpos = 5'd2;
      end else begin
         skip = 1'b1;
      end
      if (!skip && s.mpos == 5'd1) begin
         if (s.number[LB-1:LB-4] != 4'd0) s.wmask[0] = 1'b1;
         else s.number = {s.number[LB-5:0], h[3:0]};
      end
      return s;
   endfunction

   function automatic st_type line_content(input st_type s, input logic [7:0] c);
      case (s.phase)
         PH_REQ:  s = rl_byte(s, c);
         PH_HKEY: s = key_byte(s, c);
         PH_HVAL: s = val_byte(s, c);
         default: s = csize_byte(s, c);
      endcase
      return s;
   endfunction

   function automatic st_type end_headers(input st_type s, input logic [31:0] lim);
      if (!s.hflags[HF_HOST]) begin
         s = fail_with(s, ERR_BAD);
      end else if (s.hflags[HF_CL] && s.hflags[HF_CLBAD]) begin
         s = fail_with(s, ERR_BAD);
      end else if (s.hflags[HF_CL] && (s.hflags[HF_CLOVER] ||
                   CMP_W'(s.content_length) > CMP_W'(lim))) begin
         s = fail_with(s, ERR_TOOLARGE);
      end else if (s.hflags[HF_CHUNKED]) begin
         s.phase  = PH_CSIZE;
         s.mpos   = 5'd0;
         s.wmask  = 5'd0;
         s.number = '0;
      end else if (s.hflags[HF_CL]) begin
         s.chunk_remaining = s.content_length;
         s.phase = (s.content_length == '0) ? PH_DONE : PH_BODY;
      end else begin
         s.phase = PH_DONE;
      end
      return s;
   endfunction

   function automatic st_type line_end(input st_type s, input logic [31:0] lim);
      logic hit;
      hit = 1'b0;
      case (s.phase)
         PH_REQ: begin
            if (s.in_token) s = end_token(s);
            if (s.phase == PH_REQ) begin
               if (s.token_index != 2'd3) s = fail_with(s, ERR_REQLINE);
               else s = start_key(s);
            end
         end
         PH_HKEY: begin
            if (s.mpos == 5'd0) s = end_headers(s, lim);
            else s = start_key(s);
         end
         PH_HVAL: begin
            if (s.key_sel == KEY_HOST) begin
               s.hflags[HF_HOST] = 1'b1;
            end else if (s.key_sel == KEY_CLEN) begin
               s.hflags[HF_CL]     = 1'b1;
               s.hflags[HF_CLBAD]  = s.wmask[VM_BAD] || !s.wmask[VM_START];
               s.hflags[HF_CLOVER] = s.wmask[VM_OVER];
               s.content_length    = s.number;
            end else if (s.key_sel == KEY_TENC) begin
               hit = s.wmask[VM_ALIVE] && s.mpos == LEN_CHUNKED;
               s.hflags[HF_CHUNKED] = hit;
            end else if (s.key_sel == KEY_CONN) begin
               hit = s.wmask[VM_ALIVE] && s.mpos == LEN_CLOSE;
               s.hflags[HF_CLOSE] = hit;
            end
            s = start_key(s);
         end
         default: begin
            if (s.mpos == 5'd0 || s.mpos == 5'd3 || s.wmask[0]) begin
               s = fail_with(s, ERR_BAD);
            end else if (s.number == '0) begin
               s.phase = PH_DONE;
            end else begin
               s.chunk_remaining = s.number;
               s.phase = PH_CDATA;
            end
         end
      endcase
      return s;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      st_in      = st_ff;
      st_in.kind = KIND_NONE;
      st_in.data = 8'h00;
      pcr_in     = pcr_ff;
      bc_in      = bc_ff;
      done       = 1'b0;
      if (st_ff.phase inside {PH_REQ, PH_HKEY, PH_HVAL, PH_CSIZE}) begin
         if (pcr_ff) begin
            pcr_in = 1'b0;
            if (req_data_byte == CH_LF) begin
               st_in = line_end(st_in, limit_ff);
               done  = 1'b1;
            end else if (st_in.phase != PH_REQ) begin
               st_in = line_content(st_in, CH_CR);
            end
         end
         if (!done) begin
            if (req_data_byte == CH_CR) begin
               if (st_in.phase == PH_REQ) st_in = rl_byte(st_in, req_data_byte);
               pcr_in = 1'b1;
            end else begin
               st_in = line_content(st_in, req_data_byte);
            end
         end
      end else begin
         case (st_ff.phase)
            PH_CDATA: begin
               if (bc_ff >= limit_ff) begin
                  st_in = fail_with(st_in, ERR_TOOLARGE);
               end else begin
                  st_in.kind = KIND_BODY;
                  st_in.data = req_data_byte;
                  bc_in = bc_ff + 32'd1;
                  st_in.chunk_remaining = st_ff.chunk_remaining - LB'(1);
                  if (st_in.chunk_remaining == '0) begin
                     st_in.phase = PH_CEND;
                     st_in.mpos  = 5'd0;
                  end
               end
            end
            PH_CEND: begin
               if (st_ff.mpos == 5'd0) begin
                  if (req_data_byte == CH_CR) st_in.mpos = 5'd1;
                  else st_in = fail_with(st_in, ERR_BAD);
               end else if (req_data_byte == CH_LF) begin
                  st_in.phase  = PH_CSIZE;
                  st_in.mpos   = 5'd0;
                  st_in.wmask  = 5'd0;
                  st_in.number = '0;
               end else begin
                  st_in = fail_with(st_in, ERR_BAD);
               end
            end
            PH_BODY: begin
               st_in.kind = KIND_BODY;
               st_in.data = req_data_byte;
               if (bc_ff != 32'hFFFF_FFFF) bc_in = bc_ff + 32'd1;
               st_in.chunk_remaining = st_ff.chunk_remaining - LB'(1);
               if (st_in.chunk_remaining == '0) st_in.phase = PH_DONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase           <= PH_REQ;
         st_ff.token_index     <= 2'd0;
         st_ff.wmask           <= 5'h1F;
         st_ff.mpos            <= 5'd0;
         st_ff.hflags          <= 6'd0;
         st_ff.number          <= '0;
         st_ff.content_length  <= '0;
         st_ff.chunk_remaining <= '0;
         st_ff.err             <= ERR_NONE;
         st_ff.method          <= METH_NONE;
         st_ff.in_token        <= 1'b0;
         st_ff.key_sel         <= KEY_NONE;
         st_ff.kind            <= KIND_NONE;
         st_ff.data            <= 8'h00;
         pcr_ff                <= 1'b0;
         bc_ff                 <= 32'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (accept) begin
            st_ff  <= st_in;
            pcr_ff <= pcr_in;
            bc_ff  <= bc_in;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= BODY_LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= st_in.kind;
         data_ff     <= st_in.data;
         finished_ff <= (st_in.phase == PH_DONE);
         failed_ff   <= (st_in.phase == PH_FAIL);
         err_ff      <= st_in.err;
         meth_ff     <= st_in.method;
         keep_ff     <= !st_in.hflags[HF_CLOSE];
         count_ff    <= bc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_kind   = kind_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_finished    = finished_ff;
   assign rsp_failed      = failed_ff;
   assign rsp_error_kind  = err_ff;
   assign rsp_method_code = meth_ff;
   assign rsp_keep_alive  = keep_ff;
   assign rsp_body_count  = count_ff;

   `ASSERT_NEVER(a_done_and_fail, clock, reset, rsp_valid && rsp_finished && rsp_failed, "finished and failed together")
   `ASSERT_PROP(a_fail_has_code, clock, reset, (rsp_valid && rsp_failed) |-> (rsp_error_kind != ERR_NONE), "failure without error code")
   `ASSERT_PROP(a_fail_sticks, clock, reset, (st_ff.phase == PH_FAIL) |=> (st_ff.phase == PH_FAIL), "left failed phase")
   `ASSERT_PROP(a_done_sticks, clock, reset, (st_ff.phase == PH_DONE) |=> (st_ff.phase == PH_DONE), "left finished phase")
   `ASSERT_PROP(a_body_counted, clock, reset, (rsp_valid && rsp_byte_kind == KIND_BODY) |-> (rsp_body_count != 32'd0), "body byte not counted")

endmodule

`default_nettype wire
